### rtl/core/acfc_pkg.sv
// acfc_pkg: shared types and constants for the ascii command frame checker
// no dependencies; used by every module in rtl/core
package acfc_pkg;

  // ascii codes the framing logic looks for
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharS      = 8'h53;
  localparam logic [7:0] CharA      = 8'h41;
  localparam logic [7:0] CharQ      = 8'h51;

  // result status codes
  localparam logic [1:0] StatusAccepted   = 2'd0;
  localparam logic [1:0] StatusBadFraming = 2'd1;
  localparam logic [1:0] StatusMismatch   = 2'd2;
  localparam logic [1:0] StatusUnknownCmd = 2'd3;

  // decoded command codes
  localparam logic [1:0] CmdSetOne = 2'd0;
  localparam logic [1:0] CmdSetAll = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;
  localparam logic [1:0] CmdOther  = 2'd3;

  // phases of the checksum text reader
  typedef enum logic [2:0] {
    PhBlank  = 3'd0,
    PhSign   = 3'd1,
    PhZero   = 3'd2,
    PhPrefix = 3'd3,
    PhDigits = 3'd4,
    PhDone   = 3'd5
  } hex_phase_t;

  // control from the line tracker to the hex reader
  typedef struct packed {
    logic clear;
    logic feed;
  } hex_ctl_t;

  // one result request
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] command;
    logic [7:0] raw_letter;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [6:0] line_length;
  } result_t;

endpackage

### rtl/core/acfc_hex_parser.sv
// acfc_hex_parser: reads the checksum text after the star, strtol style, base 16
// depends on acfc_pkg (hex_phase_t, hex_ctl_t, character constants)
module acfc_hex_parser (
  input  logic              clk,
  input  logic              rst,
  input  acfc_pkg::hex_ctl_t ctl,
  input  logic [7:0]        data_byte,
  output logic [7:0]        received_sum
);

  acfc_pkg::hex_phase_t phase, phase_next;
  logic [7:0] value, value_next;
  logic       negative, negative_next;
  logic       is_digit;
  logic [3:0] digit;
  logic       is_blank;

  // hex digit decode
  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    if (data_byte inside {[8'h30:8'h39]}) begin
      digit = 4'(data_byte - 8'h30);
    end else if (data_byte inside {[8'h61:8'h66]}) begin
      digit = 4'(data_byte - 8'h57);
    end else if (data_byte inside {[8'h41:8'h46]}) begin
      digit = 4'(data_byte - 8'h37);
    end else begin
      is_digit = 1'b0;
    end
    is_blank = data_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C};
  end

  // next phase, value and sign
  always_comb begin
    phase_next    = phase;
    value_next    = value;
    negative_next = negative;
    if (ctl.clear) begin
      phase_next    = acfc_pkg::PhBlank;
      value_next    = 8'd0;
      negative_next = 1'b0;
    end else if (ctl.feed) begin
      if (data_byte == acfc_pkg::CharNul) begin
        phase_next = acfc_pkg::PhDone;
      end else begin
        case (phase)
          acfc_pkg::PhBlank: begin
            if (is_blank) begin
              phase_next = acfc_pkg::PhBlank;
            end else if (data_byte == 8'h2B) begin
              phase_next = acfc_pkg::PhSign;
            end else if (data_byte == 8'h2D) begin
              negative_next = 1'b1;
              phase_next    = acfc_pkg::PhSign;
            end else if (data_byte == 8'h30) begin
              phase_next = acfc_pkg::PhZero;
            end else if (is_digit) begin
              value_next = {value[3:0], digit};
              phase_next = acfc_pkg::PhDigits;
            end else begin
              phase_next = acfc_pkg::PhDone;
            end
          end
          acfc_pkg::PhSign: begin
            if (data_byte == 8'h30) begin
              phase_next = acfc_pkg::PhZero;
            end else if (is_digit) begin
              value_next = {value[3:0], digit};
              phase_next = acfc_pkg::PhDigits;
            end else begin
              phase_next = acfc_pkg::PhDone;
            end
          end
          acfc_pkg::PhZero: begin
            if (data_byte inside {8'h78, 8'h58}) begin
              phase_next = acfc_pkg::PhPrefix;
            end else if (is_digit) begin
              value_next = {value[3:0], digit};
              phase_next = acfc_pkg::PhDigits;
            end else begin
              phase_next = acfc_pkg::PhDone;
            end
          end
          acfc_pkg::PhPrefix, acfc_pkg::PhDigits: begin
            if (is_digit) begin
              value_next = {value[3:0], digit};
              phase_next = acfc_pkg::PhDigits;
            end else begin
              phase_next = acfc_pkg::PhDone;
            end
          end
          default: begin
            phase_next = acfc_pkg::PhDone;
          end
        endcase
      end
    end
  end

  // phase register and value
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= acfc_pkg::PhBlank;
      value    <= 8'd0;
      negative <= 1'b0;
    end else begin
      phase    <= phase_next;
      value    <= value_next;
      negative <= negative_next;
    end
  end

  // a minus sign negates modulo 256
  assign received_sum = negative ? 8'(8'd0 - value) : value;

endmodule

### rtl/core/acfc_line_tracker.sv
// acfc_line_tracker: per-line framing state, running xor and result build
// depends on acfc_pkg and acfc_hex_parser
module acfc_line_tracker #(
  parameter int LINE_MAX = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  output logic              res_fire,
  output acfc_pkg::result_t result
);

  localparam int CntW  = $clog2(LINE_MAX);
  localparam int WideW = (CntW > 7) ? CntW : 7;

  logic [CntW-1:0] byte_count, byte_count_next;
  logic            starts_with_dollar, starts_with_dollar_next;
  logic [7:0]      cmd_letter, cmd_letter_next;
  logic            star_seen, star_seen_next;
  logic            string_ended, string_ended_next;
  logic [7:0]      running_xor, running_xor_next;

  logic               is_term;
  logic               has_room;
  logic               line_clear;
  acfc_pkg::hex_ctl_t hex_ctl;
  logic [7:0]         hex_sum;
  logic [WideW-1:0]   count_wide;
  logic               framed;

  assign is_term  = (data_byte == acfc_pkg::CharLf) || (data_byte == acfc_pkg::CharCr);
  assign has_room = byte_count < CntW'(LINE_MAX - 1);

  // a terminator or an overflow byte returns the line to reset values
  assign line_clear    = step && (is_term || !has_room);
  assign hex_ctl.clear = line_clear;
  assign hex_ctl.feed  = step && !is_term && has_room && (byte_count != '0) && star_seen;
  assign res_fire      = step && is_term && (byte_count != '0);

  acfc_hex_parser u_hex (
    .clk          (clk),
    .rst          (rst),
    .ctl          (hex_ctl),
    .data_byte    (data_byte),
    .received_sum (hex_sum)
  );

  // store one byte of the line
  always_comb begin
    byte_count_next         = byte_count;
    starts_with_dollar_next = starts_with_dollar;
    cmd_letter_next         = cmd_letter;
    star_seen_next          = star_seen;
    string_ended_next       = string_ended;
    running_xor_next        = running_xor;
    if (line_clear) begin
      byte_count_next         = '0;
      starts_with_dollar_next = 1'b0;
      cmd_letter_next         = 8'd0;
      star_seen_next          = 1'b0;
      string_ended_next       = 1'b0;
      running_xor_next        = 8'd0;
    end else if (step) begin
      byte_count_next = byte_count + 1'b1;
      if (byte_count == '0) begin
        starts_with_dollar_next = (data_byte == acfc_pkg::CharDollar);
      end else begin
        if (byte_count == CntW'(1)) begin
          cmd_letter_next = data_byte;
        end
        if (!star_seen && !string_ended) begin
          if (data_byte == acfc_pkg::CharNul) begin
            string_ended_next = 1'b1;
          end else if (data_byte == acfc_pkg::CharStar) begin
            star_seen_next = 1'b1;
          end else begin
            running_xor_next = running_xor ^ data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      starts_with_dollar <= 1'b0;
      cmd_letter         <= 8'd0;
      star_seen          <= 1'b0;
      string_ended       <= 1'b0;
      running_xor        <= 8'd0;
    end else begin
      byte_count         <= byte_count_next;
      starts_with_dollar <= starts_with_dollar_next;
      cmd_letter         <= cmd_letter_next;
      star_seen          <= star_seen_next;
      string_ended       <= string_ended_next;
      running_xor        <= running_xor_next;
    end
  end

  // result fields from the state before the terminator
  assign count_wide = WideW'(byte_count);
  assign framed     = starts_with_dollar && star_seen;

  always_comb begin
    case (cmd_letter)
      acfc_pkg::CharS: result.command = acfc_pkg::CmdSetOne;
      acfc_pkg::CharA: result.command = acfc_pkg::CmdSetAll;
      acfc_pkg::CharQ: result.command = acfc_pkg::CmdQuery;
      default:         result.command = acfc_pkg::CmdOther;
    endcase
    result.raw_letter   = cmd_letter;
    result.line_length  = count_wide[6:0];
    result.computed_sum = framed ? running_xor : 8'd0;
    result.received_sum = framed ? hex_sum : 8'd0;
    if (!framed) begin
      result.status = acfc_pkg::StatusBadFraming;
    end else if (hex_sum != running_xor) begin
      result.status = acfc_pkg::StatusMismatch;
    end else if (result.command == acfc_pkg::CmdOther) begin
      result.status = acfc_pkg::StatusUnknownCmd;
    end else begin
      result.status = acfc_pkg::StatusAccepted;
    end
  end

endmodule

### rtl/core/ascii_command_frame_checker_unit.sv
// Pipeline: a terminator is taken into the byte register, and its result request
// is then captured in the result register, where it is held until taken.
// Throughput: one byte per cycle; the byte register and the result register
// stall only while a result request is held and not taken.
// Reset: synchronous rst clears both valid flags and all line state, with the
// hex reader back in its blank skipping phase.
// depends on acfc_pkg and acfc_line_tracker
module ascii_command_frame_checker_unit #(
  parameter int LINE_MAX = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [1:0] command,
  output logic [7:0] raw_letter,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum,
  output logic [6:0] line_length
);

  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              advance;
  logic              step;
  logic              res_fire;
  acfc_pkg::result_t res_next;
  acfc_pkg::result_t res_q;

  // the pipe moves whenever the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = !byte_valid || advance;
  assign step     = byte_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= data_byte;
    end
  end

  acfc_line_tracker #(
    .LINE_MAX (LINE_MAX)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (byte_q),
    .res_fire  (res_fire),
    .result    (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      res_q <= res_next;
    end
  end

  assign status       = res_q.status;
  assign command      = res_q.command;
  assign raw_letter   = res_q.raw_letter;
  assign computed_sum = res_q.computed_sum;
  assign received_sum = res_q.received_sum;
  assign line_length  = res_q.line_length;

`ifndef SYNTHESIS
  // bad framing reports both sums as zero
  a_bad_framing_sums : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == acfc_pkg::StatusBadFraming |->
      computed_sum == 8'd0 && received_sum == 8'd0)
    else $error("bad framing request carries nonzero sums");

  // a mismatch request really has differing sums
  a_mismatch_differs : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == acfc_pkg::StatusMismatch |-> computed_sum != received_sum)
    else $error("mismatch request with equal sums");

  // accepted and unknown-command requests passed the checksum
  a_good_sum_equal : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == acfc_pkg::StatusAccepted ||
                  status == acfc_pkg::StatusUnknownCmd) |->
      computed_sum == received_sum)
    else $error("checksum-good request with differing sums");

  // accepted requests always carry a known command
  a_accepted_known_cmd : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == acfc_pkg::StatusAccepted |-> command != acfc_pkg::CmdOther)
    else $error("accepted request with unknown command");
`endif

endmodule
